// ----- design/dccc_pkg.sv -----
// ----------------------------------------------------------------------------
// dccc_pkg
// Shared constants, types and helpers of the correlation classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package dccc_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int SAMPLE_BITS = 24;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W       = SAMPLE_BITS + CNT_W - 1;
	localparam int SQ_W        = 2 * SAMPLE_BITS + CNT_W - 1;
	localparam int MUL_W       = 64;
	localparam int ADDR_W      = 5;

	localparam logic [2:0] REG_N1   = 3'd0;
	localparam logic [2:0] REG_N2   = 3'd1;
	localparam logic [2:0] REG_PC1  = 3'd2;
	localparam logic [2:0] REG_PC2  = 3'd3;
	localparam logic [2:0] REG_NC1  = 3'd4;
	localparam logic [2:0] REG_NC2  = 3'd5;
	localparam logic [2:0] REG_MODE = 3'd6;

	localparam logic [2:0] MODE_PP = 3'd0;
	localparam logic [2:0] MODE_PN = 3'd1;
	localparam logic [2:0] MODE_NP = 3'd2;
	localparam logic [2:0] MODE_PM = 3'd3;
	localparam logic [2:0] MODE_MP = 3'd4;

	localparam logic signed [15:0] NEUTRAL_HI = 16'sd16384;
	localparam logic signed [15:0] NEUTRAL_LO = -16'sd16384;

	typedef struct packed {
		logic [6:0]         n1;
		logic [6:0]         n2;
		logic signed [15:0] pc1;
		logic signed [15:0] pc2;
		logic signed [15:0] nc1;
		logic signed [15:0] nc2;
		logic [2:0]         mode;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sx;
		logic [SUM_W-1:0] sy;
		logic [SQ_W-1:0]  sxy;
		logic [SQ_W-1:0]  sxx;
		logic [SQ_W-1:0]  syy;
		logic [CNT_W-1:0] n;
		logic             cond2;
		logic             same;
	} job_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [6:0] n);
		logic [CNT_W:0] w;
		w = (CNT_W+1)'(n);
		if (w < (CNT_W+1)'(2)) begin
			return CNT_W'(2);
		end else if (w > (CNT_W+1)'(MAX_SAMPLES)) begin
			return CNT_W'(MAX_SAMPLES);
		end
		return CNT_W'(w);
	endfunction

endpackage
`default_nettype wire

// ----- design/dccc_smp_if.sv -----
// ----------------------------------------------------------------------------
// dccc_smp_if
// Sample channel: one beat carries one sample pair.
// ----------------------------------------------------------------------------
`default_nettype none
interface dccc_smp_if;
	logic        valid;
	logic        ready;
	logic [23:0] tf_sample;
	logic [23:0] gene_sample;
	logic        pair_same_id;

	modport source (output valid, tf_sample, gene_sample, pair_same_id, input ready);
	modport sink (input valid, tf_sample, gene_sample, pair_same_id, output ready);
endinterface
`default_nettype wire

// ----- design/dccc_res_if.sv -----
// ----------------------------------------------------------------------------
// dccc_res_if
// Result channel: one beat carries the classification of one pair.
// ----------------------------------------------------------------------------
`default_nettype none
interface dccc_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] r_cond1;
	logic signed [15:0] r_cond2;
	logic               is_edge;
	logic               degenerate;
	logic [31:0]        edge_index;

	modport source (output valid, r_cond1, r_cond2, is_edge, degenerate, edge_index,
		input ready);
	modport sink (input valid, r_cond1, r_cond2, is_edge, degenerate, edge_index,
		output ready);
endinterface
`default_nettype wire

// ----- design/dccc_front.sv -----
// ----------------------------------------------------------------------------
// dccc_front
// Takes samples, forms the five sums per condition and queues each closed
// condition as a job.
// ----------------------------------------------------------------------------
`default_nettype none
module dccc_front import dccc_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  cfg_t cfg,
	dccc_smp_if.sink   smp,
	output job_t       job,
	output logic       push,
	input  wire  logic full
);

	logic [CNT_W-1:0]       idx_q;
	logic                   cond2_q;
	logic [SUM_W-1:0]       sx_q, sy_q;
	logic [SQ_W-1:0]        sxy_q, sxx_q, syy_q;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic [2*SAMPLE_BITS-1:0] pxy_s1, pxx_s1, pyy_s1;
	logic                   last_s1, cond2_s1, same_s1;
	logic [CNT_W-1:0]       n_s1;

	logic                   stall, accept, last;
	logic [CNT_W-1:0]       taken, lim;
	logic [SUM_W-1:0]       sx_n, sy_n;
	logic [SQ_W-1:0]        sxy_n, sxx_n, syy_n;

	assign stall     = valid_s1 && last_s1 && full;
	assign smp.ready = !stall;
	assign accept    = smp.valid && !stall;
	assign taken     = idx_q + CNT_W'(1);
	assign lim       = clamp_count(cond2_q ? cfg.n2 : cfg.n1);
	assign last      = taken >= lim;

	assign sx_n  = sx_q + SUM_W'(x_s1);
	assign sy_n  = sy_q + SUM_W'(y_s1);
	assign sxy_n = sxy_q + SQ_W'(pxy_s1);
	assign sxx_n = sxx_q + SQ_W'(pxx_s1);
	assign syy_n = syy_q + SQ_W'(pyy_s1);

	assign push      = valid_s1 && last_s1 && !full;
	assign job.sx    = sx_n;
	assign job.sy    = sy_n;
	assign job.sxy   = sxy_n;
	assign job.sxx   = sxx_n;
	assign job.syy   = syy_n;
	assign job.n     = n_s1;
	assign job.cond2 = cond2_s1;
	assign job.same  = same_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cond2_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= last ? '0 : taken;
				if (last) begin
					cond2_q <= !cond2_q;
				end
			end
			if (!stall) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			x_s1     <= smp.tf_sample;
			y_s1     <= smp.gene_sample;
			pxy_s1   <= smp.tf_sample * smp.gene_sample;
			pxx_s1   <= smp.tf_sample * smp.tf_sample;
			pyy_s1   <= smp.gene_sample * smp.gene_sample;
			last_s1  <= last;
			cond2_s1 <= cond2_q;
			same_s1  <= smp.pair_same_id;
			n_s1     <= taken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
			syy_q <= '0;
		end else if (valid_s1 && !stall) begin
			if (last_s1) begin
				sx_q  <= '0;
				sy_q  <= '0;
				sxy_q <= '0;
				sxx_q <= '0;
				syy_q <= '0;
			end else begin
				sx_q  <= sx_n;
				sy_q  <= sy_n;
				sxy_q <= sxy_n;
				sxx_q <= sxx_n;
				syy_q <= syy_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/dccc_queue.sv -----
// ----------------------------------------------------------------------------
// dccc_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module dccc_queue import dccc_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  job_t wr_job,
	input  wire  logic push,
	output logic       full,
	output job_t       rd_job,
	output logic       avail,
	input  wire  logic pop
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full   = cnt_q == 2'd2;
	assign avail  = cnt_q != 2'd0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

endmodule
`default_nettype wire

// ----- design/dccc_mul.sv -----
// ----------------------------------------------------------------------------
// dccc_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dccc_mul import dccc_pkg::*; (
	input  wire  logic             clk,
	input  wire  logic             arst_n,
	input  wire  logic             start,
	input  wire  logic [MUL_W-1:0] a,
	input  wire  logic [MUL_W-1:0] b,
	output logic                   done,
	output logic [2*MUL_W-1:0]     p
);

	localparam int STEP_W = $clog2(MUL_W);

	logic [MUL_W-1:0]   a_q;
	logic [2*MUL_W-1:0] prod_q;
	logic               busy_q, done_q;
	logic [STEP_W-1:0]  step_q;
	logic [MUL_W:0]     hi;

	assign hi   = {1'b0, prod_q[2*MUL_W-1:MUL_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign p    = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(MUL_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(MUL_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {hi, prod_q[MUL_W-1:1]};
		end
	end

endmodule
`default_nettype wire

// ----- design/dccc_back.sv -----
// ----------------------------------------------------------------------------
// dccc_back
// Computes one correlation per job with a shared multiplier, a square root
// and a divider, then classifies each pair and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module dccc_back import dccc_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  cfg_t cfg,
	input  wire  job_t job,
	input  wire  logic avail,
	output logic       pop,
	dccc_res_if.source res
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_DCHK = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [2:0]         op_q;
	logic               start_q;
	logic [MUL_W-1:0]   a_q, t_q, mag_q, vx_q, vy_q;
	logic               neg_q, deg_q;
	logic [2*MUL_W-1:0] v_q;
	logic [MUL_W+3:0]   srem_q;
	logic [MUL_W-1:0]   root_q, drem_q;
	logic [5:0]         cnt_q;
	logic [15:0]        frac_q;
	logic signed [15:0] held_r_q;
	logic               held_deg_q;
	logic [31:0]        edges_q;
	logic               rvalid_q;

	logic [MUL_W-1:0]   ma, mb, pl, dv, den;
	logic               mdone;
	logic [2*MUL_W-1:0] mp;
	logic [MUL_W+3:0]   ssh, trial;
	logic [MUL_W:0]     d2;
	logic signed [15:0] r, r1;
	logic               edge_hit, anydeg;
	logic               start_n, emit;

	dccc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.p      (mp)
	);

	always_comb begin
		unique case (op_q)
			3'd0: begin ma = MUL_W'(job_q.n);  mb = MUL_W'(job_q.sxy); end
			3'd1: begin ma = MUL_W'(job_q.sx); mb = MUL_W'(job_q.sy);  end
			3'd2: begin ma = MUL_W'(job_q.n);  mb = MUL_W'(job_q.sxx); end
			3'd3: begin ma = MUL_W'(job_q.sx); mb = MUL_W'(job_q.sx);  end
			3'd4: begin ma = MUL_W'(job_q.n);  mb = MUL_W'(job_q.syy); end
			3'd5: begin ma = MUL_W'(job_q.sy); mb = MUL_W'(job_q.sy);  end
			default: begin ma = vx_q; mb = vy_q; end
		endcase
	end

	assign pl    = mp[MUL_W-1:0];
	assign dv    = t_q - pl;
	assign ssh   = {srem_q[MUL_W+1:0], v_q[2*MUL_W-1:2*MUL_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign den   = (root_q == '0) ? MUL_W'(1) : root_q;
	assign d2    = {drem_q, 1'b0};

	assign r  = neg_q ? -$signed(frac_q) : (frac_q[15] ? 16'sh7fff : $signed(frac_q));
	assign r1 = held_r_q;
	assign anydeg = deg_q || held_deg_q;

	assign start_n = ((state_q == ST_IDLE) && avail && job.sx != '0 && job.sy != '0)
		|| ((state_q == ST_MUL) && mdone && op_q != 3'd6
		&& !(op_q == 3'd5 && (vx_q == '0 || dv == '0)));
	assign emit    = (state_q == ST_DONE) && job_q.cond2 && (!rvalid_q || res.ready);

	always_comb begin
		priority case (cfg.mode)
			MODE_PP: edge_hit = r1 >= cfg.pc1 && r >= cfg.pc2;
			MODE_PN: edge_hit = r1 >= cfg.pc1 && r < NEUTRAL_HI && r >= NEUTRAL_LO;
			MODE_NP: edge_hit = r >= cfg.pc2 && r1 < NEUTRAL_HI && r1 >= NEUTRAL_LO;
			MODE_PM: edge_hit = r1 >= cfg.pc1 && r < cfg.nc2;
			MODE_MP: edge_hit = r >= cfg.pc2 && r1 < cfg.nc1;
			default: edge_hit = 1'b0;
		endcase
		if (job_q.same || anydeg) begin
			edge_hit = 1'b0;
		end
	end

	assign pop       = (state_q == ST_IDLE) && avail;
	assign res.valid = rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			op_q       <= 3'd0;
			held_r_q   <= '0;
			held_deg_q <= 1'b0;
			edges_q    <= '0;
			rvalid_q   <= 1'b0;
		end else begin
			start_q <= start_n;
			if (emit) begin
				rvalid_q <= 1'b1;
			end else if (rvalid_q && res.ready) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						op_q <= 3'd0;
						if (job.sx == '0 || job.sy == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mdone) begin
						if (op_q == 3'd6) begin
							state_q <= ST_SQRT;
						end else if (op_q == 3'd5 && (vx_q == '0 || dv == '0)) begin
							state_q <= ST_DONE;
						end else begin
							op_q <= op_q + 3'd1;
						end
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'd63) begin
						state_q <= ST_DCHK;
					end
				end
				ST_DCHK: begin
					state_q <= (mag_q >= den) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 6'd14) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!job_q.cond2) begin
						held_r_q   <= r;
						held_deg_q <= deg_q;
						state_q    <= ST_IDLE;
					end else if (emit) begin
						if (edge_hit && edges_q != 32'hffff_ffff) begin
							edges_q <= edges_q + 32'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q  <= job;
				frac_q <= '0;
				neg_q  <= 1'b0;
				deg_q  <= 1'b0;
			end
			ST_MUL: begin
				if (mdone) begin
					unique case (op_q)
						3'd0: a_q <= pl;
						3'd1: begin
							neg_q <= a_q < pl;
							mag_q <= (a_q < pl) ? pl - a_q : a_q - pl;
						end
						3'd2: t_q <= pl;
						3'd3: vx_q <= dv;
						3'd4: t_q <= pl;
						3'd5: begin
							vy_q <= dv;
							if (vx_q == '0 || dv == '0) begin
								deg_q <= 1'b1;
								neg_q <= 1'b0;
							end
						end
						default: begin
							v_q    <= mp;
							srem_q <= '0;
							root_q <= '0;
							cnt_q  <= '0;
						end
					endcase
				end
			end
			ST_SQRT: begin
				cnt_q <= cnt_q + 6'd1;
				v_q   <= {v_q[2*MUL_W-3:0], 2'b00};
				if (ssh >= trial) begin
					srem_q <= ssh - trial;
					root_q <= {root_q[MUL_W-2:0], 1'b1};
				end else begin
					srem_q <= ssh;
					root_q <= {root_q[MUL_W-2:0], 1'b0};
				end
			end
			ST_DCHK: begin
				cnt_q  <= '0;
				drem_q <= mag_q;
				root_q <= den;
				frac_q <= (mag_q >= den) ? 16'h8000 : 16'h0000;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (d2 >= {1'b0, root_q}) begin
					drem_q <= MUL_W'(d2 - {1'b0, root_q});
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					drem_q <= MUL_W'(d2);
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			ST_DONE: begin
				if (emit) begin
					res.r_cond1    <= r1;
					res.r_cond2    <= r;
					res.is_edge    <= edge_hit;
					res.degenerate <= anydeg;
					res.edge_index <= edges_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/dual_condition_correlation_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// dual_condition_correlation_classifier_unit
// Streams sample pairs, computes Pearson r for two conditions and classifies
// each pair as a coexpression edge.
//
//   channel | dir | beat
//   smp     | in  | tf_sample, gene_sample, pair_same_id
//   res     | out | r_cond1, r_cond2, is_edge, degenerate, edge_index
//   apb     | in  | register writes and reads
//
// The front takes one sample per cycle unless it stalls on a full queue.
// Each closed condition runs through up to seven multiplier products, the
// square root, one check and the divider in the back. A two-entry queue lets
// the front keep taking samples meanwhile. Reset is asynchronous and clears
// all control state; smp stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_condition_correlation_classifier_unit import dccc_pkg::*; (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	dccc_smp_if.sink                smp,
	dccc_res_if.source              res,
	input  wire  logic              psel,
	input  wire  logic              penable,
	input  wire  logic              pwrite,
	input  wire  logic [ADDR_W-1:0] paddr,
	input  wire  logic [31:0]       pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	cfg_t       cfg_q;
	job_t       wr_job, rd_job;
	logic       push, full, avail, pop;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n1   <= 7'd6;
			cfg_q.n2   <= 7'd6;
			cfg_q.pc1  <= 16'sd26214;
			cfg_q.pc2  <= 16'sd26214;
			cfg_q.nc1  <= -16'sd26214;
			cfg_q.nc2  <= -16'sd26214;
			cfg_q.mode <= MODE_PP;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_N1:   cfg_q.n1   <= pwdata[6:0];
				REG_N2:   cfg_q.n2   <= pwdata[6:0];
				REG_PC1:  cfg_q.pc1  <= pwdata[15:0];
				REG_PC2:  cfg_q.pc2  <= pwdata[15:0];
				REG_NC1:  cfg_q.nc1  <= pwdata[15:0];
				REG_NC2:  cfg_q.nc2  <= pwdata[15:0];
				REG_MODE: cfg_q.mode <= pwdata[2:0];
				default:  cfg_q      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_N1:   prdata = {25'd0, cfg_q.n1};
			REG_N2:   prdata = {25'd0, cfg_q.n2};
			REG_PC1:  prdata = 32'(cfg_q.pc1);
			REG_PC2:  prdata = 32'(cfg_q.pc2);
			REG_NC1:  prdata = 32'(cfg_q.nc1);
			REG_NC2:  prdata = 32'(cfg_q.nc2);
			REG_MODE: prdata = {29'd0, cfg_q.mode};
			default:  prdata = 32'd0;
		endcase
	end

	dccc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.smp    (smp),
		.job    (wr_job),
		.push   (push),
		.full   (full)
	);

	dccc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (wr_job),
		.push   (push),
		.full   (full),
		.rd_job (rd_job),
		.avail  (avail),
		.pop    (pop)
	);

	dccc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.job    (rd_job),
		.avail  (avail),
		.pop    (pop),
		.res    (res)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the dual-condition correlation classifier. Sample
// beats are streamed in bursts, a bit-exact predictor forms the expected
// classification of each pair, and every result beat is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import dccc_pkg::*;

	typedef struct packed {
		logic signed [15:0] r1;
		logic signed [15:0] r2;
		logic               link;
		logic               deg;
		logic [31:0]        idx;
	} verdict_t;

	typedef enum int {
		VEC_POS, VEC_NEG, VEC_RAND, VEC_CONST, VEC_ZERO, VEC_NOISY
	} vec_kind_t;

	localparam int SAMPLE_MAX = 24'hFFFFFF;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1500;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	dccc_smp_if smp ();
	dccc_res_if res ();

	dual_condition_correlation_classifier_unit dut (
		.clk(clk), .arst_n(arst_n), .smp(smp), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [6:0] cfg_n1, cfg_n2;
	logic signed [15:0] cfg_pc1, cfg_pc2, cfg_nc1, cfg_nc2;
	logic [2:0] cfg_mode;

	longint unsigned acc_tf, acc_gene, acc_cross, acc_tf_sq, acc_gene_sq;
	int unsigned taken_cnt;
	bit in_second;
	logic signed [15:0] first_r;
	bit first_deg;
	logic [31:0] link_count;

	verdict_t pending_verdicts[$];
	int unsigned mismatches;
	int unsigned idle_cycles;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned count_limit(input logic [6:0] n);
		if (n < 2) begin
			return 2;
		end else if (n > MAX_SAMPLES) begin
			return MAX_SAMPLES;
		end
		return n;
	endfunction

	function automatic logic signed [15:0] pearson_r(input longint unsigned n,
		output bit deg);
		longint unsigned a, b, mag, vx, vy, den, rem, s, t;
		logic [127:0] prod;
		int unsigned frac;
		bit neg;
		deg = 1'b0;
		frac = 0;
		if (acc_tf == 0 || acc_gene == 0) begin
			return 16'sd0;
		end
		a = n * acc_cross;
		b = acc_tf * acc_gene;
		neg = a < b;
		mag = neg ? b - a : a - b;
		vx = n * acc_tf_sq - acc_tf * acc_tf;
		vy = n * acc_gene_sq - acc_gene * acc_gene;
		if (vx == 0 || vy == 0) begin
			deg = 1'b1;
			return 16'sd0;
		end
		prod = 128'(vx) * 128'(vy);
		s = 0;
		for (int bt = 62; bt >= 0; bt--) begin
			t = s | (64'd1 << bt);
			if (128'(t) * 128'(t) <= prod) begin
				s = t;
			end
		end
		den = (s == 0) ? 1 : s;
		if (mag >= den) begin
			frac = 32768;
		end else begin
			rem = mag;
			for (int i = 0; i < 15; i++) begin
				frac = frac << 1;
				if (rem >= den - rem) begin
					rem = rem - (den - rem);
					frac = frac | 1;
				end else begin
					rem = rem * 2;
				end
			end
		end
		if (neg) begin
			return 16'(-int'(frac));
		end
		return (frac > 32767) ? 16'sd32767 : 16'(frac);
	endfunction

	function automatic bit neutral(input logic signed [15:0] r);
		return r < NEUTRAL_HI && r >= NEUTRAL_LO;
	endfunction

	task automatic classify_sample(input logic [23:0] x, input logic [23:0] y,
		input logic same);
		logic signed [15:0] r;
		bit deg, link, anydeg;
		verdict_t v;
		acc_tf += x;
		acc_gene += y;
		acc_cross += longint'(x) * longint'(y);
		acc_tf_sq += longint'(x) * longint'(x);
		acc_gene_sq += longint'(y) * longint'(y);
		taken_cnt++;
		if (taken_cnt < count_limit(in_second ? cfg_n2 : cfg_n1)) begin
			return;
		end
		r = pearson_r(taken_cnt, deg);
		acc_tf = 0;
		acc_gene = 0;
		acc_cross = 0;
		acc_tf_sq = 0;
		acc_gene_sq = 0;
		taken_cnt = 0;
		if (!in_second) begin
			first_r = r;
			first_deg = deg;
			in_second = 1'b1;
			return;
		end
		in_second = 1'b0;
		anydeg = deg || first_deg;
		case (cfg_mode)
			MODE_PP: link = first_r >= cfg_pc1 && r >= cfg_pc2;
			MODE_PN: link = first_r >= cfg_pc1 && neutral(r);
			MODE_NP: link = r >= cfg_pc2 && neutral(first_r);
			MODE_PM: link = first_r >= cfg_pc1 && r < cfg_nc2;
			MODE_MP: link = r >= cfg_pc2 && first_r < cfg_nc1;
			default: link = 1'b0;
		endcase
		if (same || anydeg) begin
			link = 1'b0;
		end
		v.r1 = first_r;
		v.r2 = r;
		v.link = link;
		v.deg = anydeg;
		v.idx = link_count;
		pending_verdicts.push_back(v);
		if (link && link_count != 32'hFFFFFFFF) begin
			link_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			cfg_n1 <= 7'd6;
			cfg_n2 <= 7'd6;
			cfg_pc1 <= 16'sd26214;
			cfg_pc2 <= 16'sd26214;
			cfg_nc1 <= -16'sd26214;
			cfg_nc2 <= -16'sd26214;
			cfg_mode <= MODE_PP;
			acc_tf = 0;
			acc_gene = 0;
			acc_cross = 0;
			acc_tf_sq = 0;
			acc_gene_sq = 0;
			taken_cnt = 0;
			in_second = 1'b0;
			first_r = 16'sd0;
			first_deg = 1'b0;
			link_count = 32'd0;
		end else begin
			if (smp.valid && smp.ready) begin
				classify_sample(smp.tf_sample, smp.gene_sample, smp.pair_same_id);
			end
			if (res.valid && res.ready) begin
				got = {res.r_cond1, res.r_cond2, res.is_edge, res.degenerate,
					res.edge_index};
				if (pending_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result beat: r1=%0d r2=%0d edge=%0b deg=%0b idx=%0d",
							got.r1, got.r2, got.link, got.deg, got.idx);
					end
				end else begin
					want = pending_verdicts.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch: expected r1=%0d r2=%0d edge=%0b deg=%0b idx=%0d",
								want.r1, want.r2, want.link, want.deg, want.idx);
							$display("                 actual   r1=%0d r2=%0d edge=%0b deg=%0b idx=%0d",
								got.r1, got.r2, got.link, got.deg, got.idx);
						end
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_N1: cfg_n1 <= pwdata[6:0];
					REG_N2: cfg_n2 <= pwdata[6:0];
					REG_PC1: cfg_pc1 <= pwdata[15:0];
					REG_PC2: cfg_pc2 <= pwdata[15:0];
					REG_NC1: cfg_nc1 <= pwdata[15:0];
					REG_NC2: cfg_nc2 <= pwdata[15:0];
					REG_MODE: cfg_mode <= pwdata[2:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	int unsigned stall_phase;
	int unsigned stall_left;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res.ready <= 1'b0;
		end else begin
			case ((stall_phase / 97) % 3)
				0: res.ready <= 1'b1;
				1: res.ready <= $urandom_range(0, 1);
				default: begin
					res.ready <= 1'b0;
					stall_left <= $urandom_range(0, 30);
				end
			endcase
		end
	end

	task automatic send_sample(input logic [23:0] x, input logic [23:0] y,
		input logic same);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				smp.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		smp.valid <= 1'b1;
		smp.tf_sample <= x;
		smp.gene_sample <= y;
		smp.pair_same_id <= same;
		do begin
			@(posedge clk);
		end while (!smp.ready);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		smp.valid <= 1'b0;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		smp.valid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_value();
		int w;
		w = $urandom_range(1, 24);
		return 24'($urandom) & 24'((1 << w) - 1);
	endfunction

	task automatic send_vector(input vec_kind_t kind, input int unsigned len,
		input logic last_same);
		logic [23:0] x, y, c;
		int sh;
		c = rand_value() | 24'd1;
		sh = $urandom_range(0, 4);
		for (int i = 0; i < len; i++) begin
			x = rand_value();
			case (kind)
				VEC_POS: y = (x >> sh) + 24'(sh);
				VEC_NEG: y = SAMPLE_MAX - x;
				VEC_CONST: x = c;
				VEC_ZERO: x = 24'd0;
				VEC_NOISY: y = (x >> 1) + 24'($urandom_range(0, 4095));
				default: y = rand_value();
			endcase
			if (kind == VEC_CONST || kind == VEC_ZERO) begin
				y = rand_value();
			end
			send_sample(x, y, (i == len - 1) ? last_same : 1'($urandom));
		end
	endtask

	function automatic vec_kind_t pick_kind();
		int unsigned p;
		p = $urandom_range(0, 19);
		if (p < 7) return VEC_POS;
		if (p < 12) return VEC_NEG;
		if (p < 15) return VEC_NOISY;
		if (p < 17) return VEC_RAND;
		if (p < 18) return VEC_CONST;
		if (p < 19) return VEC_ZERO;
		return VEC_RAND;
	endfunction

	task automatic send_pair(input vec_kind_t k1, input vec_kind_t k2,
		input logic same);
		send_vector(k1, count_limit(cfg_n1), 1'($urandom));
		send_vector(k2, count_limit(cfg_n2), same);
	endtask

	task automatic test_directed();
		apb_write(REG_N1, 32'd0);
		apb_write(REG_N2, 32'd1);
		apb_write(REG_MODE, 32'(MODE_PP));
		send_pair(VEC_POS, VEC_POS, 1'b0);
		send_pair(VEC_POS, VEC_NEG, 1'b0);
		send_pair(VEC_ZERO, VEC_POS, 1'b0);
		send_pair(VEC_CONST, VEC_POS, 1'b0);
		send_pair(VEC_POS, VEC_POS, 1'b1);
		send_sample(24'hFFFFFF, 24'h000000, 1'b0);
		send_sample(24'h000000, 24'hFFFFFF, 1'b0);
		send_sample(24'hFFFFFF, 24'hFFFFFF, 1'b0);
		send_sample(24'h000001, 24'h000001, 1'b0);
		wait_idle();
	endtask

	task automatic test_modes();
		for (int m = 0; m < 8; m++) begin
			apb_write(REG_MODE, 32'(m));
			apb_write(REG_N1, $urandom_range(2, 6));
			apb_write(REG_N2, $urandom_range(2, 6));
			case ($urandom_range(0, 3))
				0: begin
					apb_write(REG_PC1, 32'h7FFF);
					apb_write(REG_NC2, 32'h8000);
				end
				1: begin
					apb_write(REG_PC1, 32'h8000);
					apb_write(REG_PC2, 32'h8000);
					apb_write(REG_NC1, 32'h7FFF);
				end
				default: begin
					apb_write(REG_PC1, $urandom_range(8000, 32000));
					apb_write(REG_PC2, $urandom_range(8000, 32000));
					apb_write(REG_NC1, 32'(-$urandom_range(8000, 32000)));
					apb_write(REG_NC2, 32'(-$urandom_range(8000, 32000)));
				end
			endcase
			for (int p = 0; p < 4; p++) begin
				send_pair(pick_kind(), pick_kind(), $urandom_range(0, 7) == 0);
			end
			wait_idle();
		end
	endtask

	task automatic test_count_change();
		apb_write(REG_MODE, 32'(MODE_PM));
		apb_write(REG_PC1, 32'd16000);
		apb_write(REG_NC2, 32'(-16000));
		apb_write(REG_N1, 32'd6);
		apb_write(REG_N2, 32'd3);
		send_vector(VEC_POS, 3, 1'b0);
		wait_idle();
		apb_write(REG_N1, 32'd2);
		send_vector(VEC_POS, 1, 1'b0);
		send_vector(VEC_NEG, 3, 1'b0);
		wait_idle();
		apb_write(REG_N1, 32'd64);
		apb_write(REG_N2, 32'd127);
		send_pair(VEC_POS, VEC_NEG, 1'b0);
		wait_idle();
		apb_write(REG_N1, 32'd5);
		apb_write(REG_N2, 32'd4);
		for (int p = 0; p < 10; p++) begin
			send_pair(pick_kind(), pick_kind(), 1'b0);
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.tf_sample = '0;
		smp.gene_sample = '0;
		smp.pair_same_id = 1'b0;
		res.ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		stall_phase = 0;
		stall_left = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_modes();
		test_count_change();
		wait_idle();
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- dual_condition_correlation_classifier_unit.f -----
design/dccc_pkg.sv
design/dccc_smp_if.sv
design/dccc_res_if.sv
design/dccc_front.sv
design/dccc_queue.sv
design/dccc_mul.sv
design/dccc_back.sv
design/dual_condition_correlation_classifier_unit.sv
tb/sv/tb.sv
